FILE: rtl/core/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Types, codes and small lookup functions shared by the PNG chunk parser.
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DIM_W     = 31;
   localparam int unsigned CHAN_W    = 3;
   localparam int unsigned STATUS_W  = 2;

   // Last position of the signature and of the 4-byte header and CRC fields
   localparam logic [WORD_W-1:0] SIG_LAST   = 32'd7;
   localparam logic [WORD_W-1:0] FIELD_LAST = 32'd3;
   localparam logic [WORD_W-1:0] SIG_LEN    = 32'd8;
   localparam logic [WORD_W-1:0] WORD_MAX   = 32'hFFFF_FFFF;

   // IHDR payload positions
   localparam logic [WORD_W-1:0] IHDR_WIDTH_END  = 32'd4;
   localparam logic [WORD_W-1:0] IHDR_HEIGHT_END = 32'd8;
   localparam logic [WORD_W-1:0] IHDR_DEPTH_POS  = 32'd8;
   localparam logic [WORD_W-1:0] IHDR_COLOR_POS  = 32'd9;

   // Chunk type codes
   localparam logic [WORD_W-1:0] KIND_IHDR = 32'h4948_4452;
   localparam logic [WORD_W-1:0] KIND_IDAT = 32'h4944_4154;
   localparam logic [WORD_W-1:0] KIND_IEND = 32'h4945_4E44;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_LEN  = 3'd1,
      PH_TYPE = 3'd2,
      PH_DATA = 3'd3,
      PH_CRC  = 3'd4,
      PH_DONE = 3'd5,
      PH_ERR  = 3'd6
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PARSING = 2'd0,
      ST_DONE    = 2'd1,
      ST_BAD_SIG = 2'd2,
      ST_NO_END  = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_file;
   } req_item_type;

   typedef struct packed {
      logic              payload_valid;
      logic [BYTE_W-1:0] payload_byte;
      status_type        status;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
      logic [BYTE_W-1:0] bit_depth;
      logic [BYTE_W-1:0] color_kind;
      logic [CHAN_W-1:0] channel_count;
      logic [WORD_W-1:0] payload_total;
      logic [WORD_W-1:0] payload_chunks;
   } rsp_item_type;

   // Fixed PNG file signature, one byte per position
   function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] val;
      case (idx)
         3'd0: val = 8'h89;
         3'd1: val = 8'h50;
         3'd2: val = 8'h4E;
         3'd3: val = 8'h47;
         3'd4: val = 8'h0D;
         3'd5: val = 8'h0A;
         3'd6: val = 8'h1A;
         3'd7: val = 8'h0A;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Colour type to number of channels; unknown types give zero
   function automatic logic [CHAN_W-1:0] channels_of(input logic [BYTE_W-1:0] kind);
      logic [CHAN_W-1:0] val;
      case (kind)
         8'd0:    val = 3'd1;
         8'd3:    val = 3'd1;
         8'd4:    val = 3'd2;
         8'd2:    val = 3'd3;
         8'd6:    val = 3'd4;
         default: val = 3'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/pcp_if.sv
// ----------------------------------------------------------------------------
// pcp channel interfaces
// Valid/ready channels for the file bytes in and the parse results out.
// ----------------------------------------------------------------------------
interface pcp_req_if;
   logic                        valid;
   logic                        ready;
   logic [pcp_pkg::BYTE_W-1:0]  data_byte;
   logic                        end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pcp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          payload_valid;
   logic [pcp_pkg::BYTE_W-1:0]    payload_byte;
   logic [pcp_pkg::STATUS_W-1:0]  status;
   logic [pcp_pkg::DIM_W-1:0]     image_width;
   logic [pcp_pkg::DIM_W-1:0]     image_height;
   logic [pcp_pkg::BYTE_W-1:0]    bit_depth;
   logic [pcp_pkg::BYTE_W-1:0]    color_kind;
   logic [pcp_pkg::CHAN_W-1:0]    channel_count;
   logic [pcp_pkg::WORD_W-1:0]    payload_total;
   logic [pcp_pkg::WORD_W-1:0]    payload_chunks;

   modport source (
      output valid, output payload_valid, output payload_byte, output status,
      output image_width, output image_height, output bit_depth, output color_kind,
      output channel_count, output payload_total, output payload_chunks,
      input  ready
   );
   modport sink (
      input  valid, input payload_valid, input payload_byte, input status,
      input  image_width, input image_height, input bit_depth, input color_kind,
      input  channel_count, input payload_total, input payload_chunks,
      output ready
   );
endinterface

FILE: rtl/core/pcp_in_stage.sv
// ----------------------------------------------------------------------------
// pcp_in_stage
// Input register: holds one file byte until the walker consumes it.
// ----------------------------------------------------------------------------
module pcp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   pcp_req_if.sink               req_chan,
   input  logic                  advance,
   output logic                  item_valid,
   output pcp_pkg::req_item_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   pcp_pkg::req_item_type item_ff;
   logic                  take;

   // Refill in the same cycle the held byte moves on
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.data_byte   <= req_chan.data_byte;
         item_ff.end_of_file <= req_chan.end_of_file;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/pcp_walker.sv
// ----------------------------------------------------------------------------
// pcp_walker
// Chunk walker: parse state, IHDR capture and IDAT counters, one byte a step.
// ----------------------------------------------------------------------------
module pcp_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pcp_pkg::req_item_type item,
   output pcp_pkg::rsp_item_type result
);

   pcp_pkg::phase_type                phase_ff, phase_in, upd_phase;
   logic [pcp_pkg::WORD_W-1:0]        count_ff, count_in, upd_count;
   logic [pcp_pkg::WORD_W-1:0]        len_ff, len_in, upd_len;
   logic [pcp_pkg::WORD_W-1:0]        kind_ff, kind_in, upd_kind;
   logic [pcp_pkg::DIM_W-1:0]         width_ff, width_in, upd_width;
   logic [pcp_pkg::DIM_W-1:0]         height_ff, height_in, upd_height;
   logic [pcp_pkg::BYTE_W-1:0]        depth_ff, depth_in, upd_depth;
   logic [pcp_pkg::BYTE_W-1:0]        color_ff, color_in, upd_color;
   logic [pcp_pkg::CHAN_W-1:0]        chan_ff, chan_in, upd_chan;
   logic [pcp_pkg::WORD_W-1:0]        total_ff, total_in, upd_total;
   logic [pcp_pkg::WORD_W-1:0]        chunks_ff, chunks_in, upd_chunks;

   logic [pcp_pkg::BYTE_W-1:0]        b;
   logic                              last;
   logic [pcp_pkg::WORD_W-1:0]        len_shift;
   logic [pcp_pkg::WORD_W-1:0]        kind_shift;
   logic [pcp_pkg::WORD_W-1:0]        count_inc;
   logic [pcp_pkg::WORD_W:0]          total_sum;
   logic [pcp_pkg::WORD_W:0]          count_inc_w;
   logic                              data_end;
   logic                              field_end;

   assign b           = item.data_byte;
   assign last        = item.end_of_file;
   assign len_shift   = {len_ff[23:0], b};
   assign kind_shift  = {kind_ff[23:0], b};
   assign count_inc   = count_ff + 32'd1;
   assign count_inc_w = {1'b0, count_ff} + 33'd1;
   assign total_sum   = {1'b0, total_ff} + {1'b0, len_ff};
   assign data_end    = count_inc_w >= {1'b0, len_ff};
   assign field_end   = count_ff >= pcp_pkg::FIELD_LAST;

   // Next state
   always_comb begin
      upd_phase  = phase_ff;
      upd_count  = count_ff;
      upd_len    = len_ff;
      upd_kind   = kind_ff;
      upd_width  = width_ff;
      upd_height = height_ff;
      upd_depth  = depth_ff;
      upd_color  = color_ff;
      upd_chan   = chan_ff;
      upd_total  = total_ff;
      upd_chunks = chunks_ff;
      case (phase_ff)
         pcp_pkg::PH_SIG: begin
            if (b != pcp_pkg::sig_byte(count_ff[2:0])) begin
               upd_phase = pcp_pkg::PH_ERR;
               upd_count = '0;
            end else if (count_ff >= pcp_pkg::SIG_LAST) begin
               upd_phase = pcp_pkg::PH_LEN;
               upd_count = '0;
            end else begin
               upd_count = count_inc;
            end
         end
         pcp_pkg::PH_LEN: begin
            upd_len = len_shift;
            if (field_end) begin
               upd_phase = pcp_pkg::PH_TYPE;
               upd_count = '0;
            end else begin
               upd_count = count_inc;
            end
         end
         pcp_pkg::PH_TYPE: begin
            upd_kind = kind_shift;
            if (field_end) begin
               upd_count = '0;
               if (kind_shift == pcp_pkg::KIND_IEND) begin
                  upd_phase = pcp_pkg::PH_DONE;
               end else begin
                  if (kind_shift == pcp_pkg::KIND_IDAT) begin
                     upd_total = total_sum[pcp_pkg::WORD_W] ? pcp_pkg::WORD_MAX
                                                            : total_sum[pcp_pkg::WORD_W-1:0];
                     if (chunks_ff != pcp_pkg::WORD_MAX) begin
                        upd_chunks = chunks_ff + 32'd1;
                     end
                  end
                  upd_phase = (len_ff == '0) ? pcp_pkg::PH_CRC : pcp_pkg::PH_DATA;
               end
            end else begin
               upd_count = count_inc;
            end
         end
         pcp_pkg::PH_DATA: begin
            if (kind_ff == pcp_pkg::KIND_IHDR) begin
               if (count_ff < pcp_pkg::IHDR_WIDTH_END) begin
                  upd_width = {width_ff[22:0], b};
               end else if (count_ff < pcp_pkg::IHDR_HEIGHT_END) begin
                  upd_height = {height_ff[22:0], b};
               end else if (count_ff == pcp_pkg::IHDR_DEPTH_POS) begin
                  upd_depth = b;
               end else if (count_ff == pcp_pkg::IHDR_COLOR_POS) begin
                  upd_color = b;
                  upd_chan  = pcp_pkg::channels_of(b);
               end
            end
            if (data_end) begin
               upd_phase = pcp_pkg::PH_CRC;
               upd_count = '0;
            end else begin
               upd_count = count_inc;
            end
         end
         pcp_pkg::PH_CRC: begin
            if (field_end) begin
               upd_phase = pcp_pkg::PH_LEN;
               upd_count = '0;
               upd_len   = '0;
               upd_kind  = '0;
            end else begin
               upd_count = count_inc;
            end
         end
         default: begin
         end
      endcase
   end

   // Drop back to the reset state after the last byte of a file
   always_comb begin
      if (last) begin
         phase_in  = pcp_pkg::PH_SIG;
         count_in  = '0;
         len_in    = '0;
         kind_in   = '0;
         width_in  = '0;
         height_in = '0;
         depth_in  = '0;
         color_in  = '0;
         chan_in   = '0;
         total_in  = '0;
         chunks_in = '0;
      end else begin
         phase_in  = upd_phase;
         count_in  = upd_count;
         len_in    = upd_len;
         kind_in   = upd_kind;
         width_in  = upd_width;
         height_in = upd_height;
         depth_in  = upd_depth;
         color_in  = upd_color;
         chan_in   = upd_chan;
         total_in  = upd_total;
         chunks_in = upd_chunks;
      end
   end

   // Result for this byte
   always_comb begin
      result.payload_valid = 1'b0;
      result.payload_byte  = '0;
      if (phase_ff == pcp_pkg::PH_DATA && kind_ff == pcp_pkg::KIND_IDAT) begin
         result.payload_valid = 1'b1;
         result.payload_byte  = b;
      end
      if (upd_phase == pcp_pkg::PH_DONE) begin
         result.status = pcp_pkg::ST_DONE;
      end else if (upd_phase == pcp_pkg::PH_ERR) begin
         result.status = pcp_pkg::ST_BAD_SIG;
      end else if (last) begin
         result.status = (upd_phase == pcp_pkg::PH_SIG) ? pcp_pkg::ST_BAD_SIG
                                                        : pcp_pkg::ST_NO_END;
      end else begin
         result.status = pcp_pkg::ST_PARSING;
      end
      result.image_width    = upd_width;
      result.image_height   = upd_height;
      result.bit_depth      = upd_depth;
      result.color_kind     = upd_color;
      result.channel_count  = upd_chan;
      result.payload_total  = upd_total;
      result.payload_chunks = upd_chunks;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pcp_pkg::PH_SIG;
         count_ff  <= '0;
         len_ff    <= '0;
         kind_ff   <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         depth_ff  <= '0;
         color_ff  <= '0;
         chan_ff   <= '0;
         total_ff  <= '0;
         chunks_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         len_ff    <= len_in;
         kind_ff   <= kind_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         color_ff  <= color_in;
         chan_ff   <= chan_in;
         total_ff  <= total_in;
         chunks_ff <= chunks_in;
      end
   end

   a_sig_count_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == pcp_pkg::PH_SIG |-> count_ff < pcp_pkg::SIG_LEN)
      else $error("signature position out of range");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> phase_ff == pcp_pkg::PH_SIG && count_ff == '0
                       && total_ff == '0 && chunks_ff == '0 && len_ff == '0)
      else $error("state not cleared after last byte");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      step && result.payload_valid |->
         result.status == pcp_pkg::ST_PARSING || result.status == pcp_pkg::ST_NO_END)
      else $error("IDAT byte forwarded with a final status");

   a_counters_grow: assert property (@(posedge clock) disable iff (reset)
      step && !last |=> chunks_ff >= $past(chunks_ff) && total_ff >= $past(total_ff))
      else $error("IDAT counters went backwards within a file");

endmodule

FILE: rtl/core/pcp_out_stage.sv
// ----------------------------------------------------------------------------
// pcp_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module pcp_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  pcp_pkg::rsp_item_type result,
   output logic                  advance,
   pcp_rsp_if.source             rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   pcp_pkg::rsp_item_type rsp_ff;

   // Move the walker on whenever the result register is free or being emptied
   assign advance = item_valid && (!valid_ff || rsp_chan.ready);

   always_comb begin
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.payload_valid  = rsp_ff.payload_valid;
   assign rsp_chan.payload_byte   = rsp_ff.payload_byte;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.image_width    = rsp_ff.image_width;
   assign rsp_chan.image_height   = rsp_ff.image_height;
   assign rsp_chan.bit_depth      = rsp_ff.bit_depth;
   assign rsp_chan.color_kind     = rsp_ff.color_kind;
   assign rsp_chan.channel_count  = rsp_ff.channel_count;
   assign rsp_chan.payload_total  = rsp_ff.payload_total;
   assign rsp_chan.payload_chunks = rsp_ff.payload_chunks;

endmodule

FILE: rtl/core/png_chunk_parser_core.sv
// ----------------------------------------------------------------------------
// png_chunk_parser_core
// Byte-serial PNG container walker with IHDR capture and IDAT forwarding.
// ----------------------------------------------------------------------------
// Feed the file one byte per transfer on req_chan, flagging the final byte
// with end_of_file; every byte gives exactly one result on rsp_chan. While
// the sink is ready, the block sustains one byte per clock: the whole
// per-byte update (signature check, header assembly, IHDR capture,
// saturating IDAT counters) is a single pass of logic between the input
// register and the result register, and req_chan.ready only drops while a
// result is held in the result register and the input register is full as
// well. The result after the final byte reports the outcome, after which
// the parser is back at the start of a new file.
// ----------------------------------------------------------------------------
module png_chunk_parser_core (
   input  logic      clock,
   input  logic      reset,
   pcp_req_if.sink   req_chan,
   pcp_rsp_if.source rsp_chan
);

   // Byte held in the input register and its valid flag
   logic                  item_valid;
   pcp_pkg::req_item_type item;

   // High when the held byte is consumed by the walker this cycle
   logic                  advance;

   // Walker result for the held byte, before the result register
   pcp_pkg::rsp_item_type result;

   // Capture each byte transfer; hold it while the result side stalls
   pcp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Advance the parse state by one byte and form its result
   pcp_walker u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   // Register the result and present it until transferred
   pcp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule
